// File: sv/hps_pkg.sv
// Shared types and constants for the harmonic poll scheduler.
package hps_pkg;

  localparam int TABLE_SLOTS_DEF   = 16;
  localparam int INTERVAL_BITS_DEF = 16;
  localparam int MAX_FIRE          = 16;
  localparam int FIRE_W            = $clog2(MAX_FIRE + 1);

  typedef enum logic [2:0] {
    F_TICK = 3'd0,
    F_ENQ  = 3'd1,
    F_DEQ  = 3'd2,
    F_SET  = 3'd3,
    F_QRY  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVER = 2'd1,
    ST_NF   = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_RESP = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_FSCAN,
    S_FDIV,
    S_FCHK,
    S_FEND,
    S_FIND,
    S_OP,
    S_RMIN,
    S_RMUL,
    S_RDIV,
    S_RSTORE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] entry_id;
    logic [15:0] interval_ms;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] out_id;
    logic [1:0]  status;
    logic [15:0] out_interval;
    logic        last;
  } out_beat_t;

endpackage

// File: sv/harmonic_poll_scheduler_core.sv
// Harmonic poll scheduler: entry table, schedule rebuild and tick firing.
//
// Input channel in_valid/in_stall/in_data carries one beat per operation:
// a one-millisecond tick, enqueue, dequeue, set interval or query.
// Output channel out_valid/out_stall/out_data returns result beats; last
// marks the final beat of an operation. Codes 5 to 7 return nothing.
// One operation is worked at a time; in_stall is high until it finishes.
// A table lookup walks all slots, one per cycle. A rebuild walks the
// slots twice and runs a shared restoring divider once per valid slot.
// A tick that closes a base period runs the same divider per valid slot
// to test the iteration number. Answers are loaded into an output
// register; a stalled receiver holds that beat and the sequencer waits
// before loading the next one.
// Reset empties the table and clears the schedule; no clearing pass.
module harmonic_poll_scheduler_core
  import hps_pkg::*;
#(
  parameter int TABLE_SLOTS   = TABLE_SLOTS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int IB = INTERVAL_BITS;
  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int DW = $clog2(IB + 1);

  state_t state, state_next;

  logic              slot_valid    [TABLE_SLOTS];
  logic [63:0]       slot_id       [TABLE_SLOTS];
  logic [IB-1:0]     slot_interval [TABLE_SLOTS];
  logic [IB-1:0]     slot_multiple [TABLE_SLOTS];

  logic [IB-1:0]     base_period, largest_multiple, ms_count, iteration_count;

  logic [CW-1:0]     idx;
  logic [SW-1:0]     cur;
  logic              at_end;

  logic [2:0]        op_func;
  logic [63:0]       op_id;
  logic [IB-1:0]     op_ivl;
  logic              hit, free_ok;
  logic [SW-1:0]     hit_idx, free_idx;
  logic [1:0]        resp_status;
  logic [15:0]       resp_ivl;

  logic [63:0]       pend_id;
  logic              have_pend;
  logic [FIRE_W-1:0] fire_n;

  logic [IB-1:0]     div_rem, div_quo, div_den;
  logic [DW-1:0]     div_cnt;
  logic [IB:0]       div_trial, div_sub;
  logic              div_ge;

  logic [IB+15:0]    ivl_wide;
  logic [IB-1:0]     ivl_in;
  logic [IB+15:0]    q_wide;
  logic [IB:0]       ms_inc, iter_inc;
  logic              reb, fire, out_free, push;
  out_beat_t         push_data;
  logic [IB-1:0]     mult;

  assign cur    = idx[SW-1:0];
  assign at_end = (idx == CW'(TABLE_SLOTS));

  assign ivl_wide = {{IB{1'b0}}, in_data.interval_ms};
  assign ivl_in   = (ivl_wide[IB-1:0] == '0) ? IB'(1) : ivl_wide[IB-1:0];
  assign q_wide   = {16'b0, slot_interval[hit_idx]};

  assign ms_inc   = {1'b0, ms_count} + (IB+1)'(1);
  assign iter_inc = {1'b0, iteration_count} + (IB+1)'(1);

  assign div_trial = {div_rem, div_quo[IB-1]};
  assign div_ge    = (div_trial >= {1'b0, div_den});
  assign div_sub   = div_trial - {1'b0, div_den};

  assign mult = (div_quo == '0) ? IB'(1) : div_quo;

  assign reb = ((op_func == F_ENQ) && (hit || free_ok)) ||
               (((op_func == F_DEQ) || (op_func == F_SET)) && hit);
  assign fire     = (div_rem == '0) && (fire_n < FIRE_W'(MAX_FIRE));
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_data.func == F_TICK) state_next = S_TICK;
          else if (in_data.func == F_ENQ || in_data.func == F_DEQ ||
                   in_data.func == F_SET || in_data.func == F_QRY)
            state_next = S_FIND;
          else state_next = S_IDLE;
        end
      end
      S_TICK: begin
        if (base_period == '0 || ms_inc < {1'b0, base_period}) state_next = S_IDLE;
        else state_next = S_FSCAN;
      end
      S_FSCAN: begin
        if (at_end) state_next = S_FEND;
        else if (slot_valid[cur]) state_next = S_FDIV;
      end
      S_FDIV:   if (div_cnt == DW'(1)) state_next = S_FCHK;
      S_FCHK:   if (!(fire && have_pend && !out_free)) state_next = S_FSCAN;
      S_FEND:   if (!(have_pend && !out_free)) state_next = S_IDLE;
      S_FIND:   if (at_end) state_next = S_OP;
      S_OP:     state_next = reb ? S_RMIN : S_RESP;
      S_RMIN:   if (at_end) state_next = S_RMUL;
      S_RMUL: begin
        if (at_end) state_next = S_RESP;
        else if (slot_valid[cur]) state_next = S_RDIV;
      end
      S_RDIV:   if (div_cnt == DW'(1)) state_next = S_RSTORE;
      S_RSTORE: state_next = S_RMUL;
      S_RESP:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    push      = 1'b0;
    push_data = '0;
    unique case (state)
      S_FCHK: begin
        push              = fire && have_pend && out_free;
        push_data.kind    = KIND_FIRE;
        push_data.out_id  = pend_id;
      end
      S_FEND: begin
        push              = have_pend && out_free;
        push_data.kind    = KIND_FIRE;
        push_data.out_id  = pend_id;
        push_data.last    = 1'b1;
      end
      S_RESP: begin
        push                   = out_free;
        push_data.kind         = KIND_RESP;
        push_data.out_id       = op_id;
        push_data.status       = resp_status;
        push_data.out_interval = resp_ivl;
        push_data.last         = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (push) out_data <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) slot_valid[i] <= 1'b0;
      base_period      <= '0;
      largest_multiple <= '0;
      ms_count         <= '0;
      iteration_count  <= IB'(1);
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_func <= in_data.func;
            op_id   <= in_data.entry_id;
            op_ivl  <= ivl_in;
            hit     <= 1'b0;
            free_ok <= 1'b0;
            idx     <= '0;
          end
        end
        S_TICK: begin
          if (base_period != '0) begin
            if (ms_inc < {1'b0, base_period}) ms_count <= ms_inc[IB-1:0];
            else begin
              ms_count  <= '0;
              fire_n    <= '0;
              have_pend <= 1'b0;
            end
          end
        end
        S_FSCAN: begin
          if (!at_end) begin
            if (slot_valid[cur]) begin
              div_rem <= '0;
              div_quo <= iteration_count;
              div_den <= slot_multiple[cur];
              div_cnt <= DW'(IB);
            end else idx <= idx + CW'(1);
          end
        end
        S_FDIV, S_RDIV: begin
          div_rem <= div_ge ? div_sub[IB-1:0] : div_trial[IB-1:0];
          div_quo <= {div_quo[IB-2:0], div_ge};
          div_cnt <= div_cnt - DW'(1);
        end
        S_FCHK: begin
          if (fire) begin
            if (!have_pend || out_free) begin
              pend_id   <= slot_id[cur];
              have_pend <= 1'b1;
              fire_n    <= fire_n + FIRE_W'(1);
              idx       <= idx + CW'(1);
            end
          end else idx <= idx + CW'(1);
        end
        S_FEND: begin
          if (!(have_pend && !out_free)) begin
            if (iter_inc > {1'b0, largest_multiple}) iteration_count <= IB'(1);
            else iteration_count <= iter_inc[IB-1:0];
          end
        end
        S_FIND: begin
          if (!at_end) begin
            if (slot_valid[cur] && slot_id[cur] == op_id) begin
              hit     <= 1'b1;
              hit_idx <= cur;
            end
            if (!slot_valid[cur] && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= cur;
            end
            idx <= idx + CW'(1);
          end
        end
        S_OP: begin
          idx         <= '0;
          resp_ivl    <= '0;
          resp_status <= ST_OK;
          if (reb) base_period <= '0;
          unique case (op_func)
            F_QRY: begin
              if (hit) resp_ivl <= q_wide[15:0];
              else resp_status <= ST_NF;
            end
            F_DEQ: begin
              if (hit) slot_valid[hit_idx] <= 1'b0;
              else resp_status <= ST_NF;
            end
            F_SET: begin
              if (hit) slot_interval[hit_idx] <= op_ivl;
              else resp_status <= ST_NF;
            end
            F_ENQ: begin
              if (hit) begin
                slot_interval[hit_idx] <= op_ivl;
                resp_status            <= ST_OVER;
              end else if (free_ok) begin
                slot_valid[free_idx]    <= 1'b1;
                slot_id[free_idx]       <= op_id;
                slot_interval[free_idx] <= op_ivl;
              end else resp_status <= ST_FULL;
            end
            default: resp_status <= ST_OK;
          endcase
        end
        S_RMIN: begin
          if (at_end) begin
            idx              <= '0;
            largest_multiple <= '0;
          end else begin
            if (slot_valid[cur] &&
                (base_period == '0 || slot_interval[cur] < base_period))
              base_period <= slot_interval[cur];
            idx <= idx + CW'(1);
          end
        end
        S_RMUL: begin
          if (at_end) begin
            ms_count        <= '0;
            iteration_count <= IB'(1);
          end else if (slot_valid[cur]) begin
            div_rem <= '0;
            div_quo <= slot_interval[cur];
            div_den <= base_period;
            div_cnt <= DW'(IB);
          end else idx <= idx + CW'(1);
        end
        S_RSTORE: begin
          slot_multiple[cur] <= mult;
          if (mult > largest_multiple) largest_multiple <= mult;
          idx <= idx + CW'(1);
        end
        S_RESP: ;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ms_below_base: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && base_period != '0) |-> (ms_count < base_period))
    else $error("ms_count reached base period while idle");

  a_iter_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && largest_multiple != '0) |->
      (iteration_count <= largest_multiple && iteration_count != '0))
    else $error("iteration count out of range");

  a_fire_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FCHK || state == S_FSCAN || state == S_FEND) |->
      (fire_n <= FIRE_W'(MAX_FIRE)))
    else $error("fire count exceeded bound");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && in_data.func <= F_QRY) |=> in_stall)
    else $error("accepted beat did not stall the input");
`endif

endmodule

// File: tb/harmonic_poll_scheduler_core_tb.sv
// Testbench for the harmonic poll scheduler: directed and random table operations and ticks.
module harmonic_poll_scheduler_core_tb;
  import hps_pkg::*;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 200000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  harmonic_poll_scheduler_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // scheduler shadow state
  logic        sh_valid [SLOTS];
  logic [63:0] sh_id    [SLOTS];
  logic [15:0] sh_ivl   [SLOTS];
  logic [15:0] sh_mult  [SLOTS];
  logic [15:0] sh_base;
  logic [15:0] sh_maxm;
  int          sh_ms;
  int          sh_iter;

  out_beat_t expected_beats[$];
  int        mismatches;
  int        idle_pct;
  int        stall_pct;
  bit        hold_off;
  int        quiet_cycles;
  logic [63:0] id_pool[8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int find_slot(logic [63:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && sh_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void add_expected(out_beat_t r);
    expected_beats = {expected_beats, r};
  endfunction

  function automatic void rebuild_schedule();
    logic [15:0] b;
    logic [15:0] m;
    b = 0;
    sh_maxm = 0;
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && (b == 0 || sh_ivl[i] < b)) b = sh_ivl[i];
    for (int i = 0; i < SLOTS; i++) begin
      if (sh_valid[i]) begin
        m = (b != 0) ? sh_ivl[i] / b : 16'd1;
        if (m < 1) m = 1;
        sh_mult[i] = m;
        if (m > sh_maxm) sh_maxm = m;
      end
    end
    sh_base = b;
    sh_ms = 0;
    sh_iter = 1;
  endfunction

  function automatic out_beat_t answer(logic [63:0] id, status_t st, logic [15:0] ivl);
    out_beat_t r;
    r.kind = KIND_RESP;
    r.out_id = id;
    r.status = st;
    r.out_interval = ivl;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void predict_schedule(in_beat_t b);
    logic [15:0] ivl;
    int s;
    int n;
    out_beat_t r;
    ivl = (b.interval_ms == 0) ? 16'd1 : b.interval_ms;
    s = find_slot(b.entry_id);
    case (b.func)
      F_TICK: begin
        if (sh_base == 0) return;
        sh_ms++;
        if (sh_ms < sh_base) return;
        sh_ms = 0;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (sh_valid[i] && sh_mult[i] != 0 && sh_iter % sh_mult[i] == 0 && n < MAX_FIRE) begin
            r = '0;
            r.kind = KIND_FIRE;
            r.out_id = sh_id[i];
            r.status = ST_OK;
            add_expected(r);
            n++;
          end
        end
        sh_iter++;
        if (sh_iter > sh_maxm) sh_iter = 1;
        if (n > 0) expected_beats[$].last = 1'b1;
      end
      F_ENQ: begin
        if (s >= 0) begin
          sh_ivl[s] = ivl;
          rebuild_schedule();
          add_expected(answer(b.entry_id, ST_OVER, 0));
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!sh_valid[i]) begin
              sh_valid[i] = 1'b1;
              sh_id[i] = b.entry_id;
              sh_ivl[i] = ivl;
              rebuild_schedule();
              add_expected(answer(b.entry_id, ST_OK, 0));
              return;
            end
          end
          add_expected(answer(b.entry_id, ST_FULL, 0));
        end
      end
      F_DEQ: begin
        if (s < 0) add_expected(answer(b.entry_id, ST_NF, 0));
        else begin
          sh_valid[s] = 1'b0;
          rebuild_schedule();
          add_expected(answer(b.entry_id, ST_OK, 0));
        end
      end
      F_SET: begin
        if (s < 0) add_expected(answer(b.entry_id, ST_NF, 0));
        else begin
          sh_ivl[s] = ivl;
          rebuild_schedule();
          add_expected(answer(b.entry_id, ST_OK, 0));
        end
      end
      F_QRY: begin
        if (s < 0) add_expected(answer(b.entry_id, ST_NF, 0));
        else add_expected(answer(b.entry_id, ST_OK, sh_ivl[s]));
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(logic [2:0] f, logic [63:0] id, logic [15:0] ivl);
    in_beat_t b;
    b.func = f;
    b.entry_id = id;
    b.interval_ms = ivl;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_schedule(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // out_stall driver
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        out_beat_t e;
        e = expected_beats.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", e, out_data);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_beat(F_TICK, 0, 0);
    send_beat(F_QRY, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_beat(F_DEQ, 0, 0);
    send_beat(F_SET, 1, 5);
    send_beat(F_ENQ, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_beat(F_ENQ, 0, 0);
    send_beat(F_ENQ, 0, 2);
    send_beat(F_QRY, 0, 0);
    send_beat(F_QRY, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_beat(3'd5, 0, 0);
    send_beat(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    repeat (5) send_beat(F_TICK, 0, 0);
    send_beat(F_SET, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_beat(F_DEQ, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_beat(F_DEQ, 0, 0);
    send_beat(F_TICK, 0, 0);
    drain();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < SLOTS + 2; i++) send_beat(F_ENQ, 64'h100 + i, 16'd1);
    send_beat(F_ENQ, 64'h100, 16'd1);
    repeat (3) send_beat(F_TICK, 0, 0);
    for (int i = 0; i < SLOTS; i++) send_beat(F_DEQ, 64'h100 + i, 0);
    drain();
  endtask

  task automatic test_random(int count);
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      if (kind < 45) send_beat(F_TICK, rand_id(), 16'($urandom));
      else if (kind < 95) begin
        logic [2:0] f;
        logic [15:0] ivl;
        f = 3'($urandom_range(F_ENQ, F_QRY));
        ivl = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        send_beat(f, ($urandom_range(9) == 0) ? rand_id() : id_pool[$urandom_range(7)], ivl);
      end else send_beat(3'($urandom_range(5, 7)), rand_id(), 16'($urandom));
    end
  endtask

  task automatic test_backpressure();
    for (int i = 0; i < 4; i++) send_beat(F_ENQ, id_pool[i], 16'(i + 1));
    drain();
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (20) send_beat(F_TICK, 0, 0);
    join
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 1'b0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < SLOTS; i++) sh_valid[i] = 1'b0;
    sh_base = 0;
    sh_maxm = 0;
    sh_ms = 0;
    sh_iter = 1;
    for (int i = 0; i < 8; i++) id_pool[i] = {$urandom, $urandom};
    id_pool[0] = 0;
    id_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(76);
    drain();
    idle_pct = 60;
    test_random(76);
    drain();
    idle_pct = 0;
    stall_pct = 60;
    test_random(76);
    drain();
    idle_pct = 21;
    stall_pct = 21;
    test_random(76);
    drain();
    idle_pct = 0;
    stall_pct = 0;
    test_backpressure();
    if (mismatches == 0 && expected_beats.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
sv/hps_pkg.sv
sv/harmonic_poll_scheduler_core.sv
tb/harmonic_poll_scheduler_core_tb.sv
